// ----- rtl/rcp_pkg.sv -----
// rcp_pkg: types, constants and result codes for the ray-crossing
// point-in-polygon core. No dependencies.
package rcp_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int EPS_LSB         = 7;
    localparam int DIR_SHIFT       = 15;
    localparam longint LIM         = longint'(EPS_LSB) << DIR_SHIFT;

    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;
    localparam int DIFF_W  = 33;
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int D_W     = 50;
    localparam int T_W     = 67;
    localparam int CMP_W   = T_W + 1 + DIR_SHIFT + 2;
    localparam int PW      = 56;

    localparam logic [IDX_W-1:0] CFG_POINT_X    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_POINT_Y    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DIR_X      = 3'd2;
    localparam logic [IDX_W-1:0] CFG_DIR_Y      = 3'd3;
    localparam logic [IDX_W-1:0] CFG_CHECK_MODE = 3'd4;

    typedef enum logic [1:0] {
        EDGE_MISS = 2'd0,
        EDGE_HIT  = 2'd1,
        EDGE_NEAR = 2'd2
    } edge_res_t;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic               last_edge;
    } in_t;

    typedef struct packed {
        logic outside;
        logic unknown;
    } out_t;

endpackage

// ----- rtl/rcp_mul.sv -----
// rcp_mul: shared signed multiplier with registered product.
// Depends on rcp_pkg.
module rcp_mul
    import rcp_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/rcp_eval.sv -----
// rcp_eval: edge classification from the normalized determinant terms.
// Depends on rcp_pkg.
module rcp_eval
    import rcp_pkg::*;
(
    input  logic signed [D_W:0]       dn,
    input  logic signed [D_W:0]       d2n,
    input  logic signed [T_W:0]       tn,
    input  logic signed [15:0]        dir_x,
    input  logic signed [15:0]        dir_y,
    input  logic                      chk,
    input  logic signed [DIFF_W-1:0]  b1,
    input  logic signed [DIFF_W-1:0]  b2,
    input  logic signed [DIFF_W-1:0]  fx,
    input  logic signed [DIFF_W-1:0]  fy,
    output edge_res_t                 res
);

    logic signed [CMP_W-1:0] dnx, ed, ned, s2, sd, t1, lim_c, abs_d2, abs_a;
    logic                    near_gen, miss_gen, use_a;
    logic signed [16:0]      den;
    logic signed [16:0]      dabs;
    logic signed [MUL_W-1:0] n0, n1, mn, mx;
    logic signed [PW-1:0]    lo, hi, bnd, nbnd;

    always_comb
    begin
        dnx   = CMP_W'(dn);
        ed    = (dnx <<< 3) - dnx;
        ned   = -ed;
        s2    = CMP_W'(d2n) <<< COORD_FRAC_BITS;
        sd    = (CMP_W'(d2n) - dnx) <<< COORD_FRAC_BITS;
        t1    = CMP_W'(tn) <<< DIR_SHIFT;
        near_gen = chk && (((ned < s2) && (s2 < ed)) || ((ned < sd) && (sd < ed)));
        miss_gen = (t1 < ned) || (s2 < ned) || (ed < sd);

        lim_c  = CMP_W'(LIM);
        abs_d2 = (d2n < 0) ? -CMP_W'(d2n) : CMP_W'(d2n);
        abs_a  = (dir_x < 0) ? -CMP_W'(dir_x) : CMP_W'(dir_x);
        use_a  = (abs_a <<< COORD_FRAC_BITS) > lim_c;
        den    = use_a ? 17'(dir_x) : 17'(dir_y);
        n0     = use_a ? MUL_W'(b1) : MUL_W'(b2);
        n1     = use_a ? MUL_W'(fx) : MUL_W'(fy);
        if (den < 0)
        begin
            dabs = -den;
            n0   = -n0;
            n1   = -n1;
        end
        else
        begin
            dabs = den;
        end
        mn   = (n0 < n1) ? n0 : n1;
        mx   = (n0 < n1) ? n1 : n0;
        lo   = PW'(mn) <<< DIR_SHIFT;
        hi   = PW'(mx) <<< DIR_SHIFT;
        bnd  = (PW'(dabs) <<< 3) - PW'(dabs);
        nbnd = -bnd;

        if (dnx < lim_c)
        begin
            if (abs_d2 > lim_c || den == 0)
                res = EDGE_MISS;
            else if (chk && lo > nbnd && lo < bnd && hi >= nbnd && hi <= bnd)
                res = EDGE_NEAR;
            else if (hi <= nbnd)
                res = EDGE_MISS;
            else
                res = EDGE_HIT;
        end
        else
        begin
            if (near_gen)
                res = EDGE_NEAR;
            else if (miss_gen)
                res = EDGE_MISS;
            else
                res = EDGE_HIT;
        end
    end

endmodule

// ----- rtl/ray_crossing_point_in_polygon_core.sv -----
// ray_crossing_point_in_polygon_core: sequencer, config registers, parity.
// Depends on rcp_pkg, rcp_mul, rcp_eval.
//
//  channel | signals                          | direction
//  edge    | in_valid, in_ready, in_data      | in
//  result  | out_valid, out_ready, out_data   | out
//  config  | cfg_we, cfg_index, cfg_data      | in
//
// Each edge is accepted in idle, then makes six multiplier issues on the
// shared 34x34 multiplier, drains, normalizes and is evaluated.
// A result waits in the output register; the next edge is taken meanwhile.
// A closing edge stalls in evaluate only while an older result is unread.
// Reset is asynchronous; parity and unknown flags clear after each polygon.
module ray_crossing_point_in_polygon_core
    import rcp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_t             out_data,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_M1   = 10'b0000000010,
        ST_M2   = 10'b0000000100,
        ST_M3   = 10'b0000001000,
        ST_M4   = 10'b0000010000,
        ST_M5   = 10'b0000100000,
        ST_M6   = 10'b0001000000,
        ST_FIN  = 10'b0010000000,
        ST_NORM = 10'b0100000000,
        ST_EVAL = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] px_reg, py_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic               chk_reg;
    logic               parity_reg, unk_reg, last_reg;
    logic               out_valid_reg;
    out_t               out_reg;

    logic signed [DIFF_W-1:0] a12_reg, a22_reg, b1_reg, b2_reg, fx_reg, fy_reg;
    logic signed [PROD_W-1:0] acc_reg, prod, diff;
    logic signed [D_W-1:0]    d_reg, d2_reg;
    logic signed [T_W-1:0]    t_reg;
    logic signed [D_W:0]      dn_reg, d2n_reg;
    logic signed [T_W:0]      tn_reg;
    logic signed [MUL_W-1:0]  op_a, op_b;
    edge_res_t                res;
    logic                     accept, eval_go, out_take;

    rcp_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    rcp_eval u_eval (
        .dn    (dn_reg),
        .d2n   (d2n_reg),
        .tn    (tn_reg),
        .dir_x (dx_reg),
        .dir_y (dy_reg),
        .chk   (chk_reg),
        .b1    (b1_reg),
        .b2    (b2_reg),
        .fx    (fx_reg),
        .fy    (fy_reg),
        .res   (res)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_take  = out_valid_reg && out_ready;
    assign eval_go   = (state_reg == ST_EVAL) && !(last_reg && out_valid_reg && !out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign diff      = acc_reg - prod;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_M1:
            begin
                op_a = MUL_W'(dx_reg);
                op_b = MUL_W'(a22_reg);
            end
            ST_M2:
            begin
                op_a = MUL_W'(a12_reg);
                op_b = MUL_W'(dy_reg);
            end
            ST_M3:
            begin
                op_a = MUL_W'(dx_reg);
                op_b = MUL_W'(b2_reg);
            end
            ST_M4:
            begin
                op_a = MUL_W'(dy_reg);
                op_b = MUL_W'(b1_reg);
            end
            ST_M5:
            begin
                op_a = MUL_W'(b1_reg);
                op_b = MUL_W'(a22_reg);
            end
            ST_M6:
            begin
                op_a = MUL_W'(b2_reg);
                op_b = MUL_W'(a12_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = ST_M4;
            ST_M4:   state_next = ST_M5;
            ST_M5:   state_next = ST_M6;
            ST_M6:   state_next = ST_FIN;
            ST_FIN:  state_next = ST_NORM;
            ST_NORM: state_next = ST_EVAL;
            ST_EVAL: if (eval_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            px_reg        <= '0;
            py_reg        <= '0;
            dx_reg        <= 16'sd16384;
            dy_reg        <= 16'sd16384;
            chk_reg       <= 1'b0;
            parity_reg    <= 1'b0;
            unk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POINT_X:    px_reg  <= cfg_data;
                    CFG_POINT_Y:    py_reg  <= cfg_data;
                    CFG_DIR_X:      dx_reg  <= cfg_data[15:0];
                    CFG_DIR_Y:      dy_reg  <= cfg_data[15:0];
                    CFG_CHECK_MODE: chk_reg <= cfg_data[0];
                    default:        ;
                endcase
            end
            if (out_take)
                out_valid_reg <= 1'b0;
            if (eval_go)
            begin
                if (last_reg)
                begin
                    parity_reg    <= 1'b0;
                    unk_reg       <= 1'b0;
                    out_valid_reg <= 1'b1;
                end
                else if (res == EDGE_HIT)
                    parity_reg <= ~parity_reg;
                else if (res == EDGE_NEAR)
                    unk_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a12_reg  <= $signed({in_data.start_x[31], in_data.start_x})
                      - $signed({in_data.end_x[31], in_data.end_x});
            a22_reg  <= $signed({in_data.start_y[31], in_data.start_y})
                      - $signed({in_data.end_y[31], in_data.end_y});
            b1_reg   <= $signed({in_data.start_x[31], in_data.start_x})
                      - $signed({px_reg[31], px_reg});
            b2_reg   <= $signed({in_data.start_y[31], in_data.start_y})
                      - $signed({py_reg[31], py_reg});
            fx_reg   <= $signed({in_data.end_x[31], in_data.end_x})
                      - $signed({px_reg[31], px_reg});
            fy_reg   <= $signed({in_data.end_y[31], in_data.end_y})
                      - $signed({py_reg[31], py_reg});
            last_reg <= in_data.last_edge;
        end
        case (state_reg)
            ST_M2, ST_M4, ST_M6: acc_reg <= prod;
            ST_M3:  d_reg  <= D_W'(diff);
            ST_M5:  d2_reg <= D_W'(diff);
            ST_FIN: t_reg  <= T_W'(diff);
            ST_NORM:
            begin
                dn_reg  <= (d_reg < 0) ? -(D_W+1)'(d_reg) : (D_W+1)'(d_reg);
                d2n_reg <= (d_reg < 0) ? -(D_W+1)'(d2_reg) : (D_W+1)'(d2_reg);
                tn_reg  <= (d_reg < 0) ? -(T_W+1)'(t_reg) : (T_W+1)'(t_reg);
            end
            default: ;
        endcase
        if (eval_go && last_reg)
        begin
            out_reg.outside <= ~((res == EDGE_HIT) ^ parity_reg);
            out_reg.unknown <= unk_reg | (res == EDGE_NEAR);
        end
    end

endmodule

// ----- rtl/rcp_checker.sv -----
// rcp_checker: port-level assertions for the core, bound to the top level.
// Depends on rcp_pkg and ray_crossing_point_in_polygon_core.
module rcp_checker
    import rcp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_data,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // block is busy right after it takes an edge transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after accept");

    // a result never shows up the cycle after an edge is taken
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result dropped or changed");

endmodule

bind ray_crossing_point_in_polygon_core rcp_checker u_rcp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
